FILE: sv/traffic_light_phase_controller_assert.svh
// ----------------------------------------------------------------------------
// Traffic light phase controller assertion macros
// Shared concurrent assertion forms used by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_PHASE_CONTROLLER_ASSERT_SVH
`define TRAFFIC_LIGHT_PHASE_CONTROLLER_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define TLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlpc: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define TLPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlpc: same-cycle check failed");

`endif

FILE: sv/tlpc_pkg.sv
// ----------------------------------------------------------------------------
// Traffic light phase controller package
// Shared widths, reset values, register indexes and payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpc_pkg;

    localparam int unsigned SecWidth   = 6;
    localparam int unsigned IrWidth    = 32;
    localparam int unsigned CfgIdxWidth = 2;

    localparam logic [SecWidth-1:0] PHASE_SECONDS_RESET = 6'd10;
    localparam logic [SecWidth-1:0] CUT_SECONDS_RESET   = 6'd5;

    localparam logic [IrWidth-1:0] IR_LOW_MASK  = 32'h0000_FFFF;
    localparam logic [IrWidth-1:0] IR_ADDRESS   = 32'h0000_BF00;
    localparam logic [7:0]         IR_BYTE_MASK = 8'hFF;

    localparam logic [CfgIdxWidth-1:0] CFG_PHASE_SECONDS = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_CUT_SECONDS   = 2'd1;

    typedef struct packed {
        logic               vehicle_seen;
        logic               walk_button;
        logic               ir_frame_valid;
        logic [IrWidth-1:0] ir_raw_code;
    } t_item;

    typedef struct packed {
        logic [1:0]          light_now;
        logic [SecWidth-1:0] shown_seconds;
    } t_result;

    typedef struct packed {
        logic [SecWidth-1:0] phase_seconds;
        logic [SecWidth-1:0] cut_seconds;
    } t_cfg;

endpackage

`default_nettype wire

FILE: sv/tlpc_in_if.sv
// ----------------------------------------------------------------------------
// Traffic light phase controller input channel
// One tick item: sensor flags and an optional raw infrared frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlpc_in_if;
    logic        valid;
    logic        ready;
    logic        vehicle_seen;
    logic        walk_button;
    logic        ir_frame_valid;
    logic [31:0] ir_raw_code;

    modport source (
        output valid, vehicle_seen, walk_button, ir_frame_valid, ir_raw_code,
        input  ready
    );
    modport sink (
        input  valid, vehicle_seen, walk_button, ir_frame_valid, ir_raw_code,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/tlpc_out_if.sv
// ----------------------------------------------------------------------------
// Traffic light phase controller output channel
// One result per tick: the lamp and the displayed countdown.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlpc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] light_now;
    logic [5:0] shown_seconds;

    modport source (
        output valid, light_now, shown_seconds,
        input  ready
    );
    modport sink (
        input  valid, light_now, shown_seconds,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/tlpc_ir_check.sv
// ----------------------------------------------------------------------------
// Infrared frame check
// Flags a received frame with the expected address and a valid command byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpc_ir_check (
    input  wire logic        i_frame_valid,
    input  wire logic [31:0] i_raw_code,
    output logic             o_frame_ok
);

    logic w_addr_ok;
    logic w_cmd_ok;

    // The command byte must be the bitwise inverse of its complement byte.
    assign w_addr_ok = (i_raw_code & tlpc_pkg::IR_LOW_MASK) == tlpc_pkg::IR_ADDRESS;
    assign w_cmd_ok  = (i_raw_code[31:24] ^ i_raw_code[23:16]) == tlpc_pkg::IR_BYTE_MASK;
    assign o_frame_ok = i_frame_valid && w_addr_ok && w_cmd_ok;

endmodule

`default_nettype wire

FILE: sv/tlpc_phase_core.sv
// ----------------------------------------------------------------------------
// Traffic light phase core
// Holds the lamp, the countdown and the cut arming, and applies one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpc_phase_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire tlpc_pkg::t_item  i_item,
    input  wire tlpc_pkg::t_cfg   i_cfg,
    output tlpc_pkg::t_result     o_result
);

`include "traffic_light_phase_controller_assert.svh"

    typedef enum logic [1:0] {
        LAMP_RED    = 2'd0,
        LAMP_YELLOW = 2'd1,
        LAMP_GREEN  = 2'd2
    } t_lamp;

    t_lamp                   r_light;
    t_lamp                   n_light;
    logic signed [7:0]       r_count;
    logic signed [7:0]       n_count;
    logic                    r_vehicle_armed;
    logic                    n_vehicle_armed;
    logic                    r_button_armed;
    logic                    n_button_armed;

    logic                    w_frame_ok;
    logic                    w_vehicle_cut;
    logic                    w_button_cut;
    logic signed [7:0]       w_cut;
    logic signed [7:0]       w_after_cut;
    logic signed [7:0]       w_after_ir;
    logic                    w_advance;
    t_lamp                   w_next_lamp;

    tlpc_ir_check u_ir_check (
        .i_frame_valid (i_item.ir_frame_valid),
        .i_raw_code    (i_item.ir_raw_code),
        .o_frame_ok    (w_frame_ok)
    );

    // Displayed value is the start-of-tick count clamped to 0..63.
    always_comb begin
        o_result.light_now = r_light;
        if (r_count[7]) begin
            o_result.shown_seconds = '0;
        end else if (r_count[6]) begin
            o_result.shown_seconds = '1;
        end else begin
            o_result.shown_seconds = r_count[5:0];
        end
    end

    always_comb begin
        unique case (r_light)
            LAMP_RED:    w_next_lamp = LAMP_YELLOW;
            LAMP_YELLOW: w_next_lamp = LAMP_GREEN;
            default:     w_next_lamp = LAMP_RED;
        endcase
    end

    always_comb begin
        w_vehicle_cut = (r_light == LAMP_RED) && r_vehicle_armed && i_item.vehicle_seen;
        w_button_cut  = (r_light == LAMP_GREEN) && r_button_armed && i_item.walk_button;
        w_cut         = (w_vehicle_cut || w_button_cut) ?
                        signed'({2'b00, i_cfg.cut_seconds}) : 8'sd0;
        w_after_cut   = r_count - w_cut;
        w_after_ir    = ((r_light == LAMP_RED) && w_frame_ok) ? 8'sd0 : w_after_cut;
        w_advance     = w_after_ir[7] || (w_after_ir == 8'sd0);

        if (w_advance) begin
            n_light         = w_next_lamp;
            n_count         = signed'({2'b00, i_cfg.phase_seconds}) - 8'sd1;
            n_vehicle_armed = 1'b1;
            n_button_armed  = 1'b1;
        end else begin
            n_light         = r_light;
            n_count         = w_after_ir - 8'sd1;
            n_vehicle_armed = r_vehicle_armed && !w_vehicle_cut;
            n_button_armed  = r_button_armed && !w_button_cut;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light         <= LAMP_RED;
            r_count         <= signed'({2'b00, tlpc_pkg::PHASE_SECONDS_RESET});
            r_vehicle_armed <= 1'b1;
            r_button_armed  <= 1'b1;
        end else if (i_step) begin
            r_light         <= n_light;
            r_count         <= n_count;
            r_vehicle_armed <= n_vehicle_armed;
            r_button_armed  <= n_button_armed;
        end
    end

    `TLPC_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !i_step,
        $stable(r_light) && $stable(r_count) && $stable(r_vehicle_armed))
    `TLPC_ASSERT_NEXT(a_advance_rearms, i_clk, i_rst_n, i_step && w_advance,
        r_vehicle_armed && r_button_armed && (r_light != $past(r_light)))
    `TLPC_ASSERT_NEXT(a_hold_keeps_lamp, i_clk, i_rst_n, i_step && !w_advance,
        (r_light == $past(r_light)) && (r_count == $past(w_after_ir) - 8'sd1))
    `TLPC_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1,
        (r_count >= -8'sd1) && (r_count <= 8'sd63))

endmodule

`default_nettype wire

FILE: sv/traffic_light_phase_controller.sv
// ----------------------------------------------------------------------------
// Traffic light phase controller
// Steps a red/yellow/green lamp with a per-phase countdown, once per tick item.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Payload
//   i_item    in         valid/ready    vehicle_seen, walk_button,
//                                       ir_frame_valid, ir_raw_code
//   o_result  out        valid/ready    light_now, shown_seconds
//   i_cfg_*   in         write enable   index 0 phase_seconds, 1 cut_seconds
//
// Each transaction on i_item yields exactly one transaction on o_result;
// the item passes through the input register and then the result register.
// One item is accepted per cycle while the output is not stalled; the whole
// tick update is one pass of logic between the input and result registers.
// i_rst_n is synchronous, active low, and restores the lamp to red, the
// countdown and both configuration registers to their defaults.
// A stalled output holds its result while the input register still takes
// one more item; after that i_item.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module traffic_light_phase_controller (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [5:0] i_cfg_data,
    tlpc_in_if.sink         i_item,
    tlpc_out_if.source      o_result
);

    // Configuration registers. Writes must arrive only while the block is idle;
    // the block does not enforce this. A new phase length takes effect at the next reload.
    tlpc_pkg::t_cfg    r_cfg;

    // Input register stage.
    logic              r_in_valid;
    tlpc_pkg::t_item   r_item;

    // Result register stage.
    logic              r_out_valid;
    tlpc_pkg::t_result r_result;

    tlpc_pkg::t_result w_core_result;
    logic              w_step;
    logic              w_in_take;

    // The held item is processed when the result register is free or is
    // being emptied in the same cycle.
    assign w_step       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_step;
    assign w_in_take    = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_seconds <= tlpc_pkg::PHASE_SECONDS_RESET;
            r_cfg.cut_seconds   <= tlpc_pkg::CUT_SECONDS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tlpc_pkg::CFG_PHASE_SECONDS: r_cfg.phase_seconds <= i_cfg_data;
                tlpc_pkg::CFG_CUT_SECONDS:   r_cfg.cut_seconds   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_take || (r_in_valid && !w_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.vehicle_seen   <= i_item.vehicle_seen;
            r_item.walk_button    <= i_item.walk_button;
            r_item.ir_frame_valid <= i_item.ir_frame_valid;
            r_item.ir_raw_code    <= i_item.ir_raw_code;
        end
    end

    tlpc_phase_core u_phase_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_result (w_core_result)
    );

    // The core reports the lamp and count as they stood before this tick,
    // which is exactly the result for the item being stepped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_step || (r_out_valid && !o_result.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_result <= w_core_result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.light_now     = r_result.light_now;
    assign o_result.shown_seconds = r_result.shown_seconds;

endmodule

`default_nettype wire

FILE: verif/tlpc_lamp_checker.sv
// ----------------------------------------------------------------------------
// Traffic light phase controller lamp checker
// Watches the tick and result channels and the register writes, keeps its own
// model of the lamp and countdown, and compares every result in order.
// ----------------------------------------------------------------------------
module tlpc_lamp_checker import tlpc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxWidth-1:0] i_cfg_index,
    input  logic [SecWidth-1:0]    i_cfg_data,
    tlpc_in_if                     tick_bus,
    tlpc_out_if                    lamp_bus,
    output int                     o_mismatches,
    output int                     o_outstanding,
    output int                     o_compared,
    output int                     o_lamp_changes,
    output int                     o_frames_honored
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ShownMax   = (1 << SecWidth) - 1;
    localparam int ReportMax  = 10;

    typedef enum logic [1:0] {
        LAMP_RED    = 2'd0,
        LAMP_YELLOW = 2'd1,
        LAMP_GREEN  = 2'd2,
        LAMP_UNUSED = 2'd3
    } t_lamp;

    t_lamp              lamp;
    int                 countdown;
    bit                 vehicle_armed;
    bit                 button_armed;
    logic [SecWidth-1:0] reload_sec;
    logic [SecWidth-1:0] cut_sec;
    t_result            expected_displays[$];
    int                 mismatches;
    int                 compared;
    int                 lamp_changes;
    int                 frames_honored;

    function automatic bit frame_ok(input logic [IrWidth-1:0] code);
        return ((code & IR_LOW_MASK) == IR_ADDRESS) &&
               ((code[31:24] ^ code[23:16]) == IR_BYTE_MASK);
    endfunction

    function automatic t_lamp lamp_after(input t_lamp now_lit);
        case (now_lit)
            LAMP_RED:    return LAMP_YELLOW;
            LAMP_YELLOW: return LAMP_GREEN;
            default:     return LAMP_RED;
        endcase
    endfunction

    // One tick: record what is displayed, then apply cuts, frame and reload.
    task automatic step_lamp(input t_item tick);
        t_result shown;
        int      clamped;
        clamped = (countdown < 0) ? 0 : ((countdown > ShownMax) ? ShownMax : countdown);
        shown.light_now     = lamp;
        shown.shown_seconds = clamped[SecWidth-1:0];
        expected_displays.push_back(shown);

        if (lamp == LAMP_RED && vehicle_armed && tick.vehicle_seen) begin
            countdown     -= int'(cut_sec);
            vehicle_armed  = 1'b0;
        end
        if (lamp == LAMP_GREEN && button_armed && tick.walk_button) begin
            countdown    -= int'(cut_sec);
            button_armed  = 1'b0;
        end
        if (lamp == LAMP_RED && tick.ir_frame_valid && frame_ok(tick.ir_raw_code)) begin
            countdown = 0;
            frames_honored++;
        end
        if (countdown <= 0) begin
            lamp          = lamp_after(lamp);
            countdown     = int'(reload_sec);
            vehicle_armed = 1'b1;
            button_armed  = 1'b1;
            lamp_changes++;
        end
        countdown -= 1;
    endtask

    task automatic compare_display(input t_result got);
        t_result want;
        if (expected_displays.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportMax)
                $display("%0t: result lamp %0d seconds %0d arrived with no tick pending",
                         $realtime, got.light_now, got.shown_seconds);
        end else begin
            want = expected_displays.pop_front();
            compared++;
            if (got.light_now !== want.light_now ||
                got.shown_seconds !== want.shown_seconds) begin
                mismatches++;
                if (mismatches <= ReportMax)
                    $display({"%0t: result %0d expected lamp %0d seconds %0d,",
                              " got lamp %0d seconds %0d"},
                             $realtime, compared, want.light_now, want.shown_seconds,
                             got.light_now, got.shown_seconds);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_item   tick;
        t_result got;
        if (!i_rst_n) begin
            lamp          = LAMP_RED;
            reload_sec    = PHASE_SECONDS_RESET;
            cut_sec       = CUT_SECONDS_RESET;
            countdown     = int'(PHASE_SECONDS_RESET);
            vehicle_armed = 1'b1;
            button_armed  = 1'b1;
            expected_displays.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PHASE_SECONDS: reload_sec = i_cfg_data;
                    CFG_CUT_SECONDS:   cut_sec    = i_cfg_data;
                    default: ;
                endcase
            end
            // Results are checked before the new tick is queued, so a result can
            // never be matched against the tick accepted on the same edge.
            if (lamp_bus.valid && lamp_bus.ready) begin
                got.light_now     = lamp_bus.light_now;
                got.shown_seconds = lamp_bus.shown_seconds;
                compare_display(got);
            end
            if (tick_bus.valid && tick_bus.ready) begin
                tick.vehicle_seen   = tick_bus.vehicle_seen;
                tick.walk_button    = tick_bus.walk_button;
                tick.ir_frame_valid = tick_bus.ir_frame_valid;
                tick.ir_raw_code    = tick_bus.ir_raw_code;
                step_lamp(tick);
            end
        end
        o_mismatches     <= mismatches;
        o_outstanding    <= expected_displays.size();
        o_compared       <= compared;
        o_lamp_changes   <= lamp_changes;
        o_frames_honored <= frames_honored;
    end

endmodule

FILE: verif/traffic_light_phase_controller_test.sv
// ----------------------------------------------------------------------------
// Traffic light phase controller testbench
// Drives directed and random ticks through the controller under several
// timing settings and idle patterns; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module traffic_light_phase_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tlpc_pkg::*;

    // Indexes beyond the two real registers; writes there must be ignored.
    localparam logic [CfgIdxWidth-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_SPARE_B = 2'd3;

    localparam int ResetCycles   = 12;
    localparam int SettleCycles  = 8;
    localparam int CycleLimit    = 200000;
    localparam int RandomPhases  = 8;
    localparam int TicksPerPhase = 128;

    // Idle patterns, cycled through by the random phases: none, sender idle,
    // receiver stalling, and both at once.
    localparam int SendIdleByMode[4] = '{0, 83, 0, 38};
    localparam int StallByMode[4]    = '{0, 0, 83, 38};

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [SecWidth-1:0]    cfg_data;

    tlpc_in_if  tick_if ();
    tlpc_out_if lamp_if ();

    int send_idle_pct;
    int stall_pct;
    int ticks_sent;
    int settings_used;
    int cycles;

    int mismatches;
    int outstanding;
    int compared;
    int lamp_changes;
    int frames_honored;

    traffic_light_phase_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (tick_if),
        .o_result    (lamp_if)
    );

    tlpc_lamp_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .tick_bus         (tick_if),
        .lamp_bus         (lamp_if),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding),
        .o_compared       (compared),
        .o_lamp_changes   (lamp_changes),
        .o_frames_honored (frames_honored)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The result side stalls at random according to the current pattern. With
    // a stall percentage of zero the ready line simply stays high.
    always @(posedge clk) begin
        lamp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("Run stopped by the watchdog after %0d cycles.", cycles);
            $display("[traffic_light_phase_controller] ERROR");
            $finish;
        end
    end

    function automatic t_item tick_of(input bit vehicle, input bit button, input bit frame,
                                      input logic [IrWidth-1:0] code);
        t_item tick;
        tick.vehicle_seen   = vehicle;
        tick.walk_button    = button;
        tick.ir_frame_valid = frame;
        tick.ir_raw_code    = code;
        return tick;
    endfunction

    // Half of the raw codes are well-formed remote frames with a random command,
    // a quarter are the same with one bit flipped (always a reject), and the
    // rest are fully random. The frame flag is only set on a quarter of ticks.
    function automatic t_item random_tick();
        t_item      tick;
        logic [7:0] cmd;
        cmd                 = 8'($urandom);
        tick.vehicle_seen   = ($urandom_range(99) < 30);
        tick.walk_button    = ($urandom_range(99) < 30);
        tick.ir_frame_valid = ($urandom_range(99) < 25);
        case ($urandom_range(3))
            0, 1:    tick.ir_raw_code = {~cmd, cmd, IR_ADDRESS[15:0]};
            2:       tick.ir_raw_code = {~cmd, cmd, IR_ADDRESS[15:0]} ^
                                        (32'd1 << $urandom_range(31));
            default: tick.ir_raw_code = $urandom;
        endcase
        return tick;
    endfunction

    // Presents one tick after an optional random gap and waits for it to be
    // accepted. Valid is left high so back-to-back ticks need no extra edge.
    task automatic send_tick(input t_item tick);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_if.valid <= 1'b0;
            @(posedge clk);
        end
        tick_if.valid          <= 1'b1;
        tick_if.vehicle_seen   <= tick.vehicle_seen;
        tick_if.walk_button    <= tick.walk_button;
        tick_if.ir_frame_valid <= tick.ir_frame_valid;
        tick_if.ir_raw_code    <= tick.ir_raw_code;
        @(posedge clk);
        while (!tick_if.ready) @(posedge clk);
        ticks_sent++;
    endtask

    // Stops sending and waits for every expected result. The checker's count
    // is registered and trails its queue, so it is trusted only after the next edge.
    task automatic drain();
        tick_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Writes both timing registers, then a spare index with random data last,
    // so a decode that aliases the spare onto a real register shows up.
    task automatic set_timing(input logic [SecWidth-1:0] reload,
                              input logic [SecWidth-1:0] cut);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PHASE_SECONDS;
        cfg_data  <= reload;
        @(posedge clk);
        cfg_index <= CFG_CUT_SECONDS;
        cfg_data  <= cut;
        @(posedge clk);
        cfg_index <= $urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B;
        cfg_data  <= SecWidth'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [SecWidth-1:0] reload_pick;
        logic [SecWidth-1:0] cut_pick;

        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= CFG_PHASE_SECONDS;
        cfg_data               <= '0;
        tick_if.valid          <= 1'b0;
        tick_if.vehicle_seen   <= 1'b0;
        tick_if.walk_button    <= 1'b0;
        tick_if.ir_frame_valid <= 1'b0;
        tick_if.ir_raw_code    <= '0;
        send_idle_pct           = 0;
        stall_pct               = 0;

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling. The countdown still starts from the reset
        // value of ten; a reload of two takes over at the first lamp change, while
        // the cut of 63 applies at once.
        set_timing(6'd2, 6'd63);
        send_tick(tick_of(0, 0, 0, 32'h0000_0000));
        // A good remote code without the frame flag must be ignored.
        send_tick(tick_of(0, 0, 0, 32'h00FF_BF00));
        send_tick(tick_of(0, 0, 1, 32'hFFFF_FFFF));
        // Correct address but command and complement do not match.
        send_tick(tick_of(0, 0, 1, 32'h12FF_BF00));
        // Correct command pair, wrong address byte.
        send_tick(tick_of(0, 0, 1, 32'h00FF_BF01));
        // The walk button means nothing while red.
        send_tick(tick_of(0, 1, 0, 32'h0000_0000));
        // A good frame while red forces the lamp on to yellow.
        send_tick(tick_of(0, 0, 1, 32'h00FF_BF00));
        // Yellow ignores the vehicle, the button and a good frame.
        send_tick(tick_of(1, 1, 1, 32'h00FF_BF00));
        send_tick(tick_of(0, 0, 0, 32'h0000_0000));
        // Green: the button cut drives the countdown below zero.
        send_tick(tick_of(0, 1, 0, 32'h0000_0000));
        // Red: the vehicle cut does the same.
        send_tick(tick_of(1, 0, 0, 32'h0000_0000));
        send_tick(tick_of(0, 0, 0, 32'h0000_0000));
        send_tick(tick_of(0, 0, 0, 32'hFFFF_FFFF));

        // Zero reload and zero cut: the lamp advances on every tick once the
        // next reload happens, and a cut of zero still uses up its arming.
        drain();
        set_timing(6'd0, 6'd0);
        send_tick(tick_of(0, 1, 0, 32'h0000_0000));
        send_tick(tick_of(0, 1, 0, 32'h0000_0000));
        send_tick(tick_of(1, 0, 0, 32'h0000_0000));
        send_tick(tick_of(1, 1, 1, 32'hFF00_BF00));
        send_tick(tick_of(0, 1, 0, 32'h0000_0000));
        send_tick(tick_of(0, 0, 1, 32'hFF00_BF00));

        // Largest reload and largest cut.
        drain();
        set_timing(6'd63, 6'd63);
        send_tick(tick_of(0, 0, 0, 32'h0000_0000));
        send_tick(tick_of(0, 1, 0, 32'h0000_0000));
        send_tick(tick_of(1, 0, 0, 32'h0000_0000));
        send_tick(tick_of(1, 1, 0, 32'h0000_0000));

        // Random part. Each phase drains, picks an idle pattern and a timing
        // setting (mostly short phases so the lamp cycles often, sometimes the
        // extremes), and sends a block of random ticks. Now and then the sender
        // also pauses mid-phase until the result side has caught up.
        for (int phase_no = 0; phase_no < RandomPhases; phase_no++) begin
            drain();
            send_idle_pct = SendIdleByMode[phase_no % 4];
            stall_pct     = StallByMode[phase_no % 4];
            case ($urandom_range(9))
                0:       reload_pick = '0;
                1:       reload_pick = '1;
                2:       reload_pick = 6'd1;
                default: reload_pick = SecWidth'($urandom_range(12, 2));
            endcase
            case ($urandom_range(9))
                0:       cut_pick = '0;
                1:       cut_pick = '1;
                default: cut_pick = SecWidth'($urandom_range(8, 1));
            endcase
            set_timing(reload_pick, cut_pick);
            for (int n = 0; n < TicksPerPhase; n++) begin
                if ($urandom_range(149) == 0)
                    drain();
                send_tick(random_tick());
            end
        end

        // Let the result side run freely and collect everything still due.
        stall_pct = 0;
        drain();

        $display("Sent %0d ticks under %0d timing settings and four idle patterns.",
                 ticks_sent, settings_used);
        $display("Compared %0d results; lamp changed %0d times, %0d remote frames honored.",
                 compared, lamp_changes, frames_honored);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[traffic_light_phase_controller] OK");
        end else begin
            $display("%0d mismatches, %0d results still due.", mismatches, outstanding);
            $display("[traffic_light_phase_controller] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/tlpc_pkg.sv
sv/tlpc_in_if.sv
sv/tlpc_out_if.sv
sv/tlpc_ir_check.sv
sv/tlpc_phase_core.sv
sv/traffic_light_phase_controller.sv
verif/tlpc_lamp_checker.sv
verif/traffic_light_phase_controller_test.sv
